// File: hw/rtl/qdbc_pkg.sv
// ----------------------------------------------------------------------------
// qdbc_pkg
// Shared types, constants and decode functions of the quadrature direction
// and button counter.
// ----------------------------------------------------------------------------
package qdbc_pkg;

  // Widest running total that the digit path handles (four decimal digits).
  localparam int unsigned DIG_BITS = 13;

  // Detent count: resting value and the two thresholds that flip direction.
  localparam logic [2:0] DETENT_REST = 3'd4;
  localparam int         DETENT_UP   = 7;
  localparam int         DETENT_DOWN = 1;

  // Button step sizes.
  localparam int unsigned BTN1_STEP = 2;
  localparam int unsigned BTN2_STEP = 4;

  // Encoder step codes.
  localparam logic signed [1:0] STEP_NONE = 2'sd0;
  localparam logic signed [1:0] STEP_CW   = -2'sd1;
  localparam logic signed [1:0] STEP_CCW  = 2'sd1;

  // Reciprocal constants for the constant divisions by 10, 100 and 1000.
  localparam int unsigned RECIP10    = 52429;
  localparam int unsigned RSH10      = 19;
  localparam int unsigned RECIP100   = 5243;
  localparam int unsigned RSH100     = 19;
  localparam int unsigned RECIP1000  = 8389;
  localparam int unsigned RSH1000    = 23;

  localparam int unsigned PROD_BITS  = 31;

  localparam logic [7:0] SEG_BLANK = 8'hFF;

  // Beat from the update stage to the digit path.
  typedef struct packed {
    logic                count_up;
    logic [DIG_BITS-1:0] total;
  } upd_beat_t;

  // Gray step of one encoder: clockwise is 3-1-0-2, counter-clockwise the reverse.
  function automatic logic signed [1:0] step_of(input logic [1:0] prev,
                                                input logic [1:0] now);
    logic signed [1:0] s;
    case ({prev, now})
      4'b11_01, 4'b01_00, 4'b00_10, 4'b10_11: s = STEP_CW;
      4'b11_10, 4'b10_00, 4'b00_01, 4'b01_11: s = STEP_CCW;
      default:                                s = STEP_NONE;
    endcase
    return s;
  endfunction

  // Active-low segment code of one decimal digit, bit0 = a .. bit6 = g.
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] c;
    case (digit)
      4'd0:    c = 8'hC0;
      4'd1:    c = 8'hF9;
      4'd2:    c = 8'hA4;
      4'd3:    c = 8'hB0;
      4'd4:    c = 8'h99;
      4'd5:    c = 8'h92;
      4'd6:    c = 8'h82;
      4'd7:    c = 8'hF8;
      4'd8:    c = 8'h80;
      4'd9:    c = 8'h98;
      default: c = SEG_BLANK;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/qdbc_update.sv
// ----------------------------------------------------------------------------
// qdbc_update
// Input register, encoder/button state update and running-total register.
// ----------------------------------------------------------------------------
module qdbc_update #(
  parameter int TOTAL_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [3:0]          in_encoder_phases,
  input  logic [1:0]          in_buttons_n,
  output logic                up_valid,
  input  logic                up_ready,
  output qdbc_pkg::upd_beat_t up_beat
);

  logic                  s1_valid_r;
  logic [3:0]            ph_r;
  logic [1:0]            lv_r;
  logic                  s2_valid_r;
  qdbc_pkg::upd_beat_t   beat_r;

  logic [1:0]            last_ph1_r, last_ph2_r;
  logic [2:0]            detent_r;
  logic                  dir_r;
  logic                  last_lv1_r, last_lv2_r;
  logic [TOTAL_BITS-1:0] total_r;

  logic                  adv1;
  logic signed [1:0]     st1, st2;
  logic signed [4:0]     cnt;
  logic [2:0]            detent_nxt;
  logic                  dir_nxt;
  logic                  press1, press2;
  logic [TOTAL_BITS-1:0] total_a, total_nxt;

  assign adv1     = s1_valid_r && (!s2_valid_r || up_ready);
  assign in_ready = !s1_valid_r || adv1;

  always_comb begin
    st1 = qdbc_pkg::step_of(last_ph1_r, ph_r[1:0]);
    st2 = qdbc_pkg::step_of(last_ph2_r, ph_r[3:2]);
    cnt = $signed({2'b00, detent_r}) + {{3{st1[1]}}, st1} + {{3{st2[1]}}, st2};
    detent_nxt = cnt[2:0];
    dir_nxt    = dir_r;
    if (cnt >= 5'(qdbc_pkg::DETENT_UP)) begin
      dir_nxt    = 1'b1;
      detent_nxt = qdbc_pkg::DETENT_REST;
    end else if (cnt <= 5'(qdbc_pkg::DETENT_DOWN)) begin
      dir_nxt    = 1'b0;
      detent_nxt = qdbc_pkg::DETENT_REST;
    end

    press1 = last_lv1_r && !lv_r[0];
    press2 = last_lv2_r && !lv_r[1];

    total_a = total_r;
    if (press1) begin
      total_a = dir_nxt ? total_r + TOTAL_BITS'(qdbc_pkg::BTN1_STEP)
                        : total_r - TOTAL_BITS'(qdbc_pkg::BTN1_STEP);
    end
    total_nxt = total_a;
    if (press2) begin
      total_nxt = dir_nxt ? total_a + TOTAL_BITS'(qdbc_pkg::BTN2_STEP)
                          : total_a - TOTAL_BITS'(qdbc_pkg::BTN2_STEP);
    end
  end

  // Control and state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      last_ph1_r <= 2'b00;
      last_ph2_r <= 2'b00;
      detent_r   <= qdbc_pkg::DETENT_REST;
      dir_r      <= 1'b1;
      last_lv1_r <= 1'b0;
      last_lv2_r <= 1'b0;
      total_r    <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv1) begin
        s2_valid_r <= 1'b1;
        last_ph1_r <= ph_r[1:0];
        last_ph2_r <= ph_r[3:2];
        detent_r   <= detent_nxt;
        dir_r      <= dir_nxt;
        last_lv1_r <= lv_r[0];
        last_lv2_r <= lv_r[1];
        total_r    <= total_nxt;
      end else if (up_ready) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ph_r <= in_encoder_phases;
      lv_r <= in_buttons_n;
    end
    if (adv1) begin
      beat_r.count_up <= dir_nxt;
      beat_r.total    <= qdbc_pkg::DIG_BITS'(total_nxt);
    end
  end

  assign up_valid = s2_valid_r;
  assign up_beat  = beat_r;

endmodule

// File: hw/rtl/qdbc_digits.sv
// ----------------------------------------------------------------------------
// qdbc_digits
// Decimal split by reciprocal multiply, then segment encode with blanking.
// ----------------------------------------------------------------------------
module qdbc_digits (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  qdbc_pkg::upd_beat_t up_beat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [9:0]          out_count_value,
  output logic                out_count_up,
  output logic [7:0]          out_seg_thousands,
  output logic [7:0]          out_seg_hundreds,
  output logic [7:0]          out_seg_tens,
  output logic [7:0]          out_seg_ones
);

  localparam int unsigned PB = qdbc_pkg::PROD_BITS;
  localparam int unsigned DB = qdbc_pkg::DIG_BITS;

  logic          q_valid_r;
  logic [DB-1:0] v_r;
  logic [3:0]    q1000_r;
  logic [6:0]    q100_r;
  logic [9:0]    q10_r;
  logic          up_r;
  logic          o_valid_r;

  logic          adv_q, adv_o;
  logic [PB-1:0] p10, p100, p1000;
  logic [DB-1:0] ones_w;
  logic [9:0]    tens_w;
  logic [6:0]    hund_w;
  logic [7:0]    s_th, s_hu, s_te;

  assign adv_o    = q_valid_r && (!o_valid_r || out_ready);
  assign up_ready = !q_valid_r || adv_o;
  assign adv_q    = up_valid && up_ready;

  assign p10   = PB'(up_beat.total) * PB'(qdbc_pkg::RECIP10);
  assign p100  = PB'(up_beat.total) * PB'(qdbc_pkg::RECIP100);
  assign p1000 = PB'(up_beat.total) * PB'(qdbc_pkg::RECIP1000);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (up_ready) begin
        q_valid_r <= up_valid;
      end
      if (adv_o) begin
        o_valid_r <= 1'b1;
      end else if (out_ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_q) begin
      v_r     <= up_beat.total;
      up_r    <= up_beat.count_up;
      q10_r   <= p10[qdbc_pkg::RSH10+9:qdbc_pkg::RSH10];
      q100_r  <= p100[qdbc_pkg::RSH100+6:qdbc_pkg::RSH100];
      q1000_r <= p1000[qdbc_pkg::RSH1000+3:qdbc_pkg::RSH1000];
    end
  end

  always_comb begin
    ones_w = v_r - DB'(q10_r) * DB'(10);
    tens_w = q10_r - 10'(q100_r) * 10'd10;
    hund_w = q100_r - 7'(q1000_r) * 7'd10;
    s_th   = qdbc_pkg::seg_code(q1000_r);
    s_hu   = qdbc_pkg::seg_code(hund_w[3:0]);
    s_te   = qdbc_pkg::seg_code(tens_w[3:0]);
    // Blank leading zeros, never the ones digit.
    if (q1000_r == 4'd0) begin
      s_th = qdbc_pkg::SEG_BLANK;
      if (hund_w == 7'd0) begin
        s_hu = qdbc_pkg::SEG_BLANK;
        if (tens_w == 10'd0) begin
          s_te = qdbc_pkg::SEG_BLANK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o) begin
      out_count_value   <= v_r[9:0];
      out_count_up      <= up_r;
      out_seg_thousands <= s_th;
      out_seg_hundreds  <= s_hu;
      out_seg_tens      <= s_te;
      out_seg_ones      <= qdbc_pkg::seg_code(ones_w[3:0]);
    end
  end

  assign out_valid = o_valid_r;

endmodule

// File: hw/rtl/quadrature_direction_button_counter.sv
// ----------------------------------------------------------------------------
// quadrature_direction_button_counter
// Two quadrature encoders set a count direction; two buttons step a running
// total that is also shown as four active-low seven-segment digits.
// ----------------------------------------------------------------------------
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+----------------------
//   in      | in_encoder_phases[3:0], in_buttons_n[1:0]| in_valid / in_ready
//   out     | out_count_value, out_count_up, out_seg_* | out_valid / out_ready
//
// One beat in, one beat out. A beat is taken every cycle when the output is
// drained; the four register stages (input, state update, decimal split,
// segment output) carry each beat in that order, and the accepting edge
// loads the input register.
// The state update sits between the input register and the total register
// and commits as the beat leaves the input register, so order is kept.
// A stall on out_ready backs up stage by stage; each stage refills in the
// cycle it empties, so throughput stays one beat per cycle while out_ready is high.
// Reset (rst_n low, synchronous) empties the pipe and restores the detent
// count to 4, direction up, button levels "pressed" and the total to zero.
//
module quadrature_direction_button_counter #(
  parameter int TOTAL_BITS = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_encoder_phases,
  input  logic [1:0] in_buttons_n,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [9:0] out_count_value,
  output logic       out_count_up,
  output logic [7:0] out_seg_thousands,
  output logic [7:0] out_seg_hundreds,
  output logic [7:0] out_seg_tens,
  output logic [7:0] out_seg_ones
);

  // Beat between the update stage and the digit path.
  logic                up_valid;
  logic                up_ready;
  qdbc_pkg::upd_beat_t up_beat;

  // Decode encoders and buttons, advance the total.
  qdbc_update #(
    .TOTAL_BITS (TOTAL_BITS)
  ) u_update (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_encoder_phases (in_encoder_phases),
    .in_buttons_n      (in_buttons_n),
    .up_valid          (up_valid),
    .up_ready          (up_ready),
    .up_beat           (up_beat)
  );

  // Split the total into decimal digits and drive the result register.
  qdbc_digits u_digits (
    .clk               (clk),
    .rst_n             (rst_n),
    .up_valid          (up_valid),
    .up_ready          (up_ready),
    .up_beat           (up_beat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_count_value   (out_count_value),
    .out_count_up      (out_count_up),
    .out_seg_thousands (out_seg_thousands),
    .out_seg_hundreds  (out_seg_hundreds),
    .out_seg_tens      (out_seg_tens),
    .out_seg_ones      (out_seg_ones)
  );

endmodule

// File: hw/rtl/qdbc_checker.sv
// ----------------------------------------------------------------------------
// qdbc_checker
// Port-level checks of the counter: reset, stall hold and digit blanking.
// ----------------------------------------------------------------------------
module qdbc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [3:0] in_encoder_phases,
  input logic [1:0] in_buttons_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [9:0] out_count_value,
  input logic       out_count_up,
  input logic [7:0] out_seg_thousands,
  input logic [7:0] out_seg_hundreds,
  input logic [7:0] out_seg_tens,
  input logic [7:0] out_seg_ones
);

  // Reset empties the pipe.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result beat holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count_value)
      && $stable(out_count_up) && $stable(out_seg_ones))
    else $error("stalled result beat changed");

  // The ones digit always shows a digit.
  a_ones_lit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_seg_ones != 8'hFF)
    else $error("ones digit blanked");

  // A shown higher digit forces the next lower one on.
  a_blank_hund: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_seg_thousands != 8'hFF |-> out_seg_hundreds != 8'hFF)
    else $error("hundreds blanked under a lit thousands digit");

  a_blank_tens: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_seg_hundreds != 8'hFF |-> out_seg_tens != 8'hFF)
    else $error("tens blanked under a lit hundreds digit");

endmodule

bind quadrature_direction_button_counter qdbc_checker u_qdbc_checker (.*);

// File: tb/sv/quadrature_direction_button_counter_test.sv
// ----------------------------------------------------------------------------
// quadrature_direction_button_counter_test
// Self-checking bench for the quadrature direction and button counter. It runs
// a short table of directed beats and then random encoder and button traffic.
// Each accepted beat goes through a local model of the detent, direction and
// total logic; each result beat is checked field by field against it or a typed row.
// ----------------------------------------------------------------------------
module quadrature_direction_button_counter_test;

  localparam int TOTAL_BITS  = 10;
  localparam int RANDOM_BEATS = 700;
  localparam int STALL_LIMIT  = 1000;  // cycles without any beat before giving up
  localparam int DRAIN_CYCLES = 8;     // idle wait after the drain for any stray beat
  localparam int MAX_REPORTS  = 10;

  // Clockwise order of phase values; counter-clockwise walks it backwards.
  localparam logic [1:0] CW_RING [0:3] = '{2'b11, 2'b01, 2'b00, 2'b10};

  // Active-low digit glyphs 0..9, bit0 = a .. bit6 = g, bit7 held high.
  localparam logic [7:0] GLYPH [0:9] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h98
  };

  localparam logic [7:0] BLANK = qdbc_pkg::SEG_BLANK;

  // How the stimulus moves one encoder on the next beat.
  typedef enum int {TURN_CW, TURN_CCW, TURN_HOLD, TURN_JUMP, TURN_NOISE} turn_t;

  // Receiver behavior for a stretch of cycles.
  typedef enum int {RX_OPEN, RX_PATTERN, RX_COIN} rx_mode_t;

  typedef struct packed {
    logic [TOTAL_BITS-1:0] total;
    logic                  up;
    logic [7:0]            thou;
    logic [7:0]            hund;
    logic [7:0]            tens;
    logic [7:0]            ones;
  } tally_t;

  // One directed beat; a typed row carries its own expected result.
  typedef struct {
    logic [3:0] enc;
    logic [1:0] btn;
    bit         typed;
    tally_t     want;
  } dir_row_t;

  localparam tally_t NO_TALLY = '0;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [3:0] in_encoder_phases = 4'b0000;
  logic [1:0] in_buttons_n = 2'b00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [9:0] out_count_value;
  logic       out_count_up;
  logic [7:0] out_seg_thousands;
  logic [7:0] out_seg_hundreds;
  logic [7:0] out_seg_tens;
  logic [7:0] out_seg_ones;

  // Side band of the driver: a typed row overrides the model's expectation.
  bit     drv_typed = 1'b0;
  tally_t drv_want = NO_TALLY;

  // Model state, at its reset values.
  logic [1:0]            prev_ph_a = 2'b00;
  logic [1:0]            prev_ph_b = 2'b00;
  int                    detent = int'(qdbc_pkg::DETENT_REST);
  logic                  dir_up = 1'b1;
  logic                  prev_lvl_a = 1'b0;  // zero level reads as pressed
  logic                  prev_lvl_b = 1'b0;
  logic [TOTAL_BITS-1:0] tally = '0;

  tally_t tally_expected [$];
  int     mismatch_count = 0;
  int     idle_run = 0;
  int     burst_left = 0;

  tally_t pred_now;
  tally_t pred_head;
  tally_t got_now;

  dir_row_t dir_rows [25];

  quadrature_direction_button_counter #(
    .TOTAL_BITS(TOTAL_BITS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_encoder_phases(in_encoder_phases),
    .in_buttons_n     (in_buttons_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_count_value  (out_count_value),
    .out_count_up     (out_count_up),
    .out_seg_thousands(out_seg_thousands),
    .out_seg_hundreds (out_seg_hundreds),
    .out_seg_tens     (out_seg_tens),
    .out_seg_ones     (out_seg_ones)
  );

  always #5 clk = ~clk;

  // Position of a phase value on the clockwise ring.
  function automatic int ring_pos(input logic [1:0] ph);
    int p;
    case (ph)
      2'b11:   p = 0;
      2'b01:   p = 1;
      2'b00:   p = 2;
      default: p = 3;
    endcase
    return p;
  endfunction

  // Detent contribution of one encoder: -1 clockwise, +1 counter-clockwise,
  // 0 for no change or a jump across the ring.
  function automatic int turn_of(input logic [1:0] was, input logic [1:0] now);
    int p;
    p = ring_pos(was);
    if (now == CW_RING[(p + 1) % 4]) return -1;
    if (now == CW_RING[(p + 3) % 4]) return 1;
    return 0;
  endfunction

  // Advance the model by one beat and return the result it should produce.
  function automatic tally_t predict_tally(input logic [3:0] enc, input logic [1:0] btn);
    tally_t r;
    int     d;
    int     v;
    int     th;
    int     hu;
    int     te;
    // Both encoders land before the threshold test, so the sum may hit 8 or 0.
    d = detent + turn_of(prev_ph_a, enc[1:0]) + turn_of(prev_ph_b, enc[3:2]);
    prev_ph_a = enc[1:0];
    prev_ph_b = enc[3:2];
    if (d >= qdbc_pkg::DETENT_UP) begin
      dir_up = 1'b1;
      d = int'(qdbc_pkg::DETENT_REST);
    end else if (d <= qdbc_pkg::DETENT_DOWN) begin
      dir_up = 1'b0;
      d = int'(qdbc_pkg::DETENT_REST);
    end
    detent = d;
    // Fresh presses only (released before, pressed now); button one goes first.
    if (prev_lvl_a && !btn[0]) begin
      tally = dir_up ? tally + TOTAL_BITS'(qdbc_pkg::BTN1_STEP)
                     : tally - TOTAL_BITS'(qdbc_pkg::BTN1_STEP);
    end
    if (prev_lvl_b && !btn[1]) begin
      tally = dir_up ? tally + TOTAL_BITS'(qdbc_pkg::BTN2_STEP)
                     : tally - TOTAL_BITS'(qdbc_pkg::BTN2_STEP);
    end
    prev_lvl_a = btn[0];
    prev_lvl_b = btn[1];
    v  = int'(tally);
    th = (v / 1000) % 10;
    hu = (v / 100) % 10;
    te = (v / 10) % 10;
    r.total = tally;
    r.up    = dir_up;
    r.thou  = GLYPH[th];
    r.hund  = GLYPH[hu];
    r.tens  = GLYPH[te];
    r.ones  = GLYPH[v % 10];
    // Blank leading zeros from the left, stopping at the first shown digit.
    if (th == 0) begin
      r.thou = BLANK;
      if (hu == 0) begin
        r.hund = BLANK;
        if (te == 0) r.tens = BLANK;
      end
    end
    return r;
  endfunction

  function automatic logic [1:0] next_phase(input logic [1:0] ph, input turn_t t);
    logic [1:0] n;
    case (t)
      TURN_CW:   n = CW_RING[(ring_pos(ph) + 1) % 4];
      TURN_CCW:  n = CW_RING[(ring_pos(ph) + 3) % 4];
      TURN_HOLD: n = ph;
      TURN_JUMP: n = ~ph;
      default:   n = 2'($urandom_range(0, 3));
    endcase
    return n;
  endfunction

  // Present one beat from a falling edge, hold it until taken, and return at
  // the next falling edge. Gaps fall between bursts of random length.
  task automatic send_beat(input logic [3:0] enc, input logic [1:0] btn,
                           input bit typed, input tally_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_encoder_phases <= enc;
    in_buttons_n      <= btn;
    drv_typed         <= typed;
    drv_want          <= want;
    in_valid          <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  // Receiver: switch between always-ready, a rotating stall mask, and coin
  // flips, each for a stretch of cycles.
  rx_mode_t   rx_mode = RX_OPEN;
  int         rx_left = 0;
  logic [7:0] rx_mask = 8'hFF;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(32, 200);
      rx_mask = 8'($urandom_range(1, 255));
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN: begin
        out_ready <= 1'b1;
      end
      RX_PATTERN: begin
        out_ready <= rx_mask[0];
        rx_mask = {rx_mask[0], rx_mask[7:1]};
      end
      default: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
    endcase
  end

  // Scoreboard: queue the expectation of each accepted input beat first, then
  // check any result beat taken at the same edge against the oldest one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pred_now = predict_tally(in_encoder_phases, in_buttons_n);
        tally_expected.push_back(drv_typed ? drv_want : pred_now);
      end
      if (out_valid && out_ready) begin
        got_now = '{out_count_value, out_count_up, out_seg_thousands,
                    out_seg_hundreds, out_seg_tens, out_seg_ones};
        if (tally_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("unexpected result beat: total=%0d up=%0b segs=%h %h %h %h",
                     got_now.total, got_now.up, got_now.thou, got_now.hund,
                     got_now.tens, got_now.ones);
          end
        end else begin
          pred_head = tally_expected.pop_front();
          if (got_now.total !== pred_head.total || got_now.up !== pred_head.up ||
              got_now.thou !== pred_head.thou || got_now.hund !== pred_head.hund ||
              got_now.tens !== pred_head.tens || got_now.ones !== pred_head.ones) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("mismatch: expected total=%0d up=%0b segs=%h %h %h %h",
                       pred_head.total, pred_head.up, pred_head.thou,
                       pred_head.hund, pred_head.tens, pred_head.ones);
              $display("          actual   total=%0d up=%0b segs=%h %h %h %h",
                       got_now.total, got_now.up, got_now.thou,
                       got_now.hund, got_now.tens, got_now.ones);
            end
          end
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run = 0;
    end else begin
      idle_run++;
    end
    if (idle_run >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  logic [3:0] rnd_enc;
  logic [1:0] rnd_btn;
  bit         lean_ccw;
  int         pick;
  turn_t      turn;

  initial begin
    // Directed beats. Encoder nibble is {encoder two, encoder one}; buttons
    // are active low. Typed rows: after reset, direction flip to down, wrap
    // below zero, and wrap back to zero.
    dir_rows = '{
      // held through reset: no press counted
      '{4'b0000, 2'b00, 1'b1, '{10'd0, 1'b1, BLANK, BLANK, BLANK, 8'hC0}},
      '{4'b0000, 2'b11, 1'b0, NO_TALLY},   // release both
      '{4'b0000, 2'b10, 1'b0, NO_TALLY},   // press one: +2
      '{4'b0000, 2'b00, 1'b0, NO_TALLY},   // press two, one still held: +4
      '{4'b0000, 2'b11, 1'b0, NO_TALLY},
      '{4'b0000, 2'b00, 1'b0, NO_TALLY},   // both at once: +2 then +4
      '{4'b0001, 2'b11, 1'b0, NO_TALLY},   // encoder one counter-clockwise
      '{4'b0011, 2'b11, 1'b0, NO_TALLY},
      '{4'b0010, 2'b11, 1'b0, NO_TALLY},   // reaches 7: up
      '{4'b0011, 2'b11, 1'b0, NO_TALLY},   // clockwise back down
      '{4'b0001, 2'b11, 1'b0, NO_TALLY},
      // reaches 1: direction down
      '{4'b0000, 2'b11, 1'b1, '{10'd12, 1'b0, BLANK, BLANK, 8'hF9, 8'hA4}},
      '{4'b0000, 2'b10, 1'b0, NO_TALLY},   // press one while down: -2
      '{4'b0110, 2'b11, 1'b0, NO_TALLY},   // opposite turns cancel
      '{4'b1001, 2'b11, 1'b0, NO_TALLY},   // both bits flip on each: no step
      '{4'b1001, 2'b11, 1'b0, NO_TALLY},   // phases unchanged
      '{4'b0011, 2'b11, 1'b0, NO_TALLY},   // both counter-clockwise
      '{4'b0110, 2'b11, 1'b0, NO_TALLY},   // sum hits 8: up
      '{4'b0011, 2'b11, 1'b0, NO_TALLY},   // both clockwise
      '{4'b1001, 2'b11, 1'b0, NO_TALLY},   // sum hits 0: down
      '{4'b1001, 2'b00, 1'b0, NO_TALLY},   // both pressed: -6
      '{4'b1001, 2'b11, 1'b0, NO_TALLY},
      // -6 again wraps below zero
      '{4'b1001, 2'b00, 1'b1, '{10'd1022, 1'b0, 8'hF9, 8'hC0, 8'hA4, 8'hA4}},
      '{4'b0011, 2'b11, 1'b0, NO_TALLY},
      // turn to up and press in the same beat: new direction applies, wraps to 0
      '{4'b0110, 2'b10, 1'b1, '{10'd0, 1'b1, BLANK, BLANK, BLANK, 8'hC0}}
    };

    // Hold reset, then release it on a falling edge.
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].enc, dir_rows[i].btn, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random traffic: mostly clean Gray steps leaning one way so the detent
    // count crosses its thresholds often, with some jumps, noise and presses.
    rnd_enc  = dir_rows[24].enc;
    rnd_btn  = dir_rows[24].btn;
    lean_ccw = 1'b0;
    repeat (RANDOM_BEATS) begin
      if ($urandom_range(0, 19) == 0) lean_ccw = ~lean_ccw;
      for (int e = 0; e < 2; e++) begin
        pick = $urandom_range(0, 19);
        if (pick < 11)      turn = lean_ccw ? TURN_CCW : TURN_CW;
        else if (pick < 15) turn = lean_ccw ? TURN_CW : TURN_CCW;
        else if (pick < 18) turn = TURN_HOLD;
        else if (pick < 19) turn = TURN_JUMP;
        else                turn = TURN_NOISE;
        rnd_enc[2*e +: 2] = next_phase(rnd_enc[2*e +: 2], turn);
      end
      if ($urandom_range(0, 24) == 0) begin
        rnd_btn = 2'($urandom_range(0, 3));
      end else begin
        if ($urandom_range(0, 2) == 0) rnd_btn[0] = ~rnd_btn[0];
        if ($urandom_range(0, 2) == 0) rnd_btn[1] = ~rnd_btn[1];
      end
      send_beat(rnd_enc, rnd_btn, 1'b0, NO_TALLY);
    end
    in_valid <= 1'b0;

    // Drain, then give the pipe time to show any stray beat.
    while (tally_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
